### hw/rtl/shp_pkg.sv
// ----------------------------------------------------------------------------
// shp_pkg
// Types and constants shared by the sync header packetizer.
// ----------------------------------------------------------------------------
package shp_pkg;

  localparam int PAY_W      = 12;
  localparam int SYNC_W     = 32;
  localparam int PNUM_W     = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int PHASE_W    = 4;

  localparam logic [PAY_W-1:0]     PAYLOAD_SIZE_RESET = 12'd1432;
  localparam logic [SYNC_W-1:0]    SYNC_WORD_RESET    = 32'hFEFD_FCFB;

  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_SIZE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WORD      = 1'd1;

  // phase of the byte sequencer: 0..7 header bytes, 8 the payload byte
  localparam logic [PHASE_W-1:0]   PHASE_FIRST_HDR    = 4'd0;
  localparam logic [PHASE_W-1:0]   PHASE_PAYLOAD      = 4'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       header_flag;
    logic       end_of_packet;
    logic       run_last;
  } out_word_t;

endpackage

### hw/rtl/sync_header_packetizer.sv
// ----------------------------------------------------------------------------
// sync_header_packetizer
// Splits a byte stream into packets, each led by a sync word and packet number.
// ----------------------------------------------------------------------------
// One input word is one payload byte; the output carries one byte a cycle
// unless out_stall holds it. A word that does not open a packet gives one
// byte and words follow back to back. A word that opens a packet gives nine
// bytes: eight header bytes (sync word, then packet number msb first) and the
// payload byte, all out of the single output byte stage; input stalls meanwhile.
// The next word is taken in the cycle the last byte of the current word is taken.
module sync_header_packetizer #(
  parameter int COUNT_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  shp_pkg::in_word_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output shp_pkg::out_word_t               out_data,
  input  logic                             cfg_we,
  input  logic [shp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [shp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import shp_pkg::*;

  localparam int CMP_W = (COUNT_BITS + 1 > PAY_W) ? COUNT_BITS + 1 : PAY_W;

  logic [PAY_W-1:0]          payload_size_r;
  logic [SYNC_W-1:0]         sync_word_r;
  logic [COUNT_BITS-1:0]     byte_count_r;
  logic [PNUM_W-1:0]         packet_number_r;

  logic                      hold_valid_r;
  logic [PHASE_W-1:0]        phase_r;
  logic [SYNC_W+PNUM_W-1:0]  hdr_r;
  logic [7:0]                data_r;
  logic                      close_r;

  logic                      in_acc;
  logic                      out_acc;
  logic                      last_phase;
  logic                      opens;
  logic [COUNT_BITS:0]       count_nxt;
  logic [CMP_W-1:0]          count_ext;
  logic [CMP_W-1:0]          size_ext;
  logic                      close_nxt;
  logic [PNUM_W-1:0]         pnum_nxt;
  logic [5:0]                hdr_lsb;

  assign last_phase = (phase_r == PHASE_PAYLOAD);
  assign out_valid  = hold_valid_r;
  assign out_acc    = hold_valid_r && !out_stall;
  assign in_stall   = hold_valid_r && !(last_phase && out_acc);
  assign in_acc     = in_valid && !in_stall;

  assign opens     = (byte_count_r == '0);
  assign count_nxt = {1'b0, byte_count_r} + {{COUNT_BITS{1'b0}}, 1'b1};
  assign count_ext = CMP_W'(count_nxt);
  assign size_ext  = CMP_W'(payload_size_r);
  // close on buffer end, on reaching the size, or when the counter fills
  assign close_nxt = in_data.buffer_end || (count_ext == size_ext) || count_nxt[COUNT_BITS];
  assign pnum_nxt  = opens ? packet_number_r + PNUM_W'(1) : packet_number_r;

  // header byte p sits at bits 8*(7-p) and up
  assign hdr_lsb = {~phase_r[2:0], 3'b000};

  always_comb begin
    out_data.header_flag   = !last_phase;
    out_data.end_of_packet = last_phase && close_r;
    out_data.run_last      = last_phase;
    if (last_phase) begin
      out_data.out_byte = data_r;
    end else begin
      out_data.out_byte = hdr_r[hdr_lsb +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      payload_size_r <= PAYLOAD_SIZE_RESET;
      sync_word_r    <= SYNC_WORD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAYLOAD_SIZE: payload_size_r <= cfg_data[PAY_W-1:0];
        CFG_SYNC_WORD:    sync_word_r    <= cfg_data[SYNC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r    <= '0;
      packet_number_r <= '0;
      hold_valid_r    <= 1'b0;
      phase_r         <= PHASE_PAYLOAD;
    end else begin
      if (in_acc) begin
        hold_valid_r    <= 1'b1;
        phase_r         <= opens ? PHASE_FIRST_HDR : PHASE_PAYLOAD;
        byte_count_r    <= close_nxt ? '0 : count_nxt[COUNT_BITS-1:0];
        packet_number_r <= in_data.buffer_end ? '0 : pnum_nxt;
      end else if (out_acc) begin
        if (last_phase) begin
          hold_valid_r <= 1'b0;
        end else begin
          phase_r <= phase_r + PHASE_W'(1);
        end
      end
    end
  end

  // word payload, loaded on accept
  always_ff @(posedge clk) begin
    if (in_acc) begin
      hdr_r   <= {sync_word_r, pnum_nxt};
      data_r  <= in_data.data_byte;
      close_r <= close_nxt;
    end
  end

endmodule
